/* rtl/pipc_pkg.sv */
// shared types, constants and edge arithmetic for the point-in-polygon crossing test
// no dependencies

package pipc_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
  localparam int DATA_WIDTH  = 2 * COORD_WIDTH;
  localparam int OUT_WIDTH   = 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_POINT  = 1'b0,
    OP_VERTEX = 1'b1
  } op_t;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  // edge_a: previous -> current vertex, edge_b: current -> first vertex (last only)
  typedef struct packed {
    logic clear;
    logic edge_a;
    logic edge_b;
    pt_t  query;
    pt_t  prev;
    pt_t  cur;
    pt_t  first;
  } job_t;

  typedef struct packed {
    logic  straddle;
    logic  dpos;
    prod_t lhs;
    prod_t rhs;
  } edge_term_t;

  function automatic edge_term_t edge_term(pt_t q, pt_t pi, pt_t pj);
    edge_term_t r;
    diff_t d;
    diff_t dqx;
    diff_t dxj;
    diff_t dqy;
    d   = diff_t'($signed(pj.y)) - diff_t'($signed(pi.y));
    dqx = diff_t'($signed(q.x))  - diff_t'($signed(pi.x));
    dxj = diff_t'($signed(pj.x)) - diff_t'($signed(pi.x));
    dqy = diff_t'($signed(q.y))  - diff_t'($signed(pi.y));
    r.straddle = ($signed(pi.y) > $signed(q.y)) != ($signed(pj.y) > $signed(q.y));
    r.dpos     = !d[DIFF_WIDTH-1] && (d != '0);
    r.lhs      = dqx * d;
    r.rhs      = dxj * dqy;
    return r;
  endfunction

  function automatic logic edge_cross(edge_term_t t);
    logic lt;
    if (t.dpos) begin
      lt = $signed(t.lhs) < $signed(t.rhs);
    end else begin
      lt = $signed(t.rhs) < $signed(t.lhs);
    end
    return t.straddle && lt;
  endfunction

endpackage

/* rtl/pipc_front.sv */
// front end: accepts items, tracks query point, first and previous vertex, builds edge jobs
// depends on pipc_pkg

module pipc_front import pipc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  op_t  in_op,
  input  pt_t  in_pt,
  input  logic in_last,
  input  logic queue_full,
  output logic in_ready,
  output logic push,
  output job_t push_job
);

  pt_t  query;
  pt_t  first;
  pt_t  prev;
  logic seen_vertex;

  logic accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept;

  always_comb begin
    push_job.clear  = (in_op == OP_POINT);
    push_job.edge_a = (in_op == OP_VERTEX) && seen_vertex;
    push_job.edge_b = (in_op == OP_VERTEX) && in_last;
    push_job.query  = query;
    push_job.prev   = prev;
    push_job.cur    = in_pt;
    push_job.first  = seen_vertex ? first : in_pt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query       <= '0;
      first       <= '0;
      prev        <= '0;
      seen_vertex <= 1'b0;
    end else if (accept) begin
      if (in_op == OP_POINT) begin
        query       <= in_pt;
        seen_vertex <= 1'b0;
      end else begin
        if (!seen_vertex) begin
          first <= in_pt;
        end
        prev        <= in_pt;
        seen_vertex <= !in_last;
      end
    end
  end

endmodule

/* rtl/pipc_queue.sv */
// short job queue between front and back, register based
// depends on pipc_pkg

module pipc_queue import pipc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  job_t                  entries [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr;
  logic [QPTR_WIDTH-1:0] rd_ptr;
  logic [QCNT_WIDTH-1:0] count;

  logic do_push;
  logic do_pop;

  assign full       = (count == QCNT_WIDTH'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_WIDTH'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_WIDTH'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_WIDTH'(1);
        2'b01:   count <= count - QCNT_WIDTH'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_WIDTH'(QUEUE_DEPTH)) else $error("queue count overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr)) else $error("empty queue with pointer gap");

endmodule

/* rtl/pipc_back.sv */
// back end: cross products, crossing compare, parity and result register
// depends on pipc_pkg

module pipc_back import pipc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  input  job_t job,
  output logic job_pop,
  output logic out_valid,
  input  logic out_ready,
  output logic out_inside
);

  logic       en;
  logic       s1_valid;
  logic       s1_clear;
  logic       s1_edge_a;
  logic       s1_edge_b;
  edge_term_t s1_term_a;
  edge_term_t s1_term_b;

  logic parity;
  logic cross_a;
  logic cross_b;
  logic parity_acc;

  assign en      = !out_valid || out_ready;
  assign job_pop = en && job_valid;

  // products stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_clear  <= job.clear;
      s1_edge_a <= job.edge_a;
      s1_edge_b <= job.edge_b;
      s1_term_a <= edge_term(job.query, job.prev, job.cur);
      s1_term_b <= edge_term(job.query, job.cur, job.first);
    end
  end

  // compare and parity
  always_comb begin
    cross_a    = s1_edge_a && edge_cross(s1_term_a);
    cross_b    = s1_edge_b && edge_cross(s1_term_b);
    parity_acc = parity ^ cross_a ^ cross_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= 1'b0;
    end else if (en && s1_valid) begin
      if (s1_clear || s1_edge_b) begin
        parity <= 1'b0;
      end else begin
        parity <= parity_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s1_valid && !s1_clear && s1_edge_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid && s1_edge_b) begin
      out_inside <= parity_acc;
    end
  end

  a_clear_parity: assert property (@(posedge clk) disable iff (rst)
    (en && s1_valid && s1_clear) |=> (parity == 1'b0)) else $error("parity not cleared");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_edge_b)) else $error("result without last vertex");

  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    (!en && s1_valid) |=> s1_valid) else $error("stage lost while stalled");

  a_clear_no_edge: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_clear) |-> !(s1_edge_a || s1_edge_b)) else $error("point job with edges");

endmodule

/* rtl/point_in_polygon_crossing.sv */
// top level of the even-odd ray-casting point-in-polygon test
// depends on pipc_pkg, pipc_front, pipc_queue, pipc_back
//
//  channel  dir  handshake          tdata                       tuser   tlast
//  s_*      in   s_tvalid/s_tready  [15:0] coord_x [31:16] coord_y  op  last
//  m_*      out  m_tvalid/m_tready  [0] inside_res, [7:1] zero  -       -
//
// one item per cycle sustained while results are taken; after its last vertex a result
// passes the queue register, the product stage and the result register
// rst is synchronous and clears the query point, vertex tracking, parity and queue
// a held result stalls the back end only; the front keeps taking items until the queue fills

module point_in_polygon_crossing import pipc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [DATA_WIDTH-1:0] s_tdata,   // coord_x, coord_y
  input  logic                  s_tuser,   // op
  input  logic                  s_tlast,   // last
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_WIDTH-1:0]  m_tdata    // inside_res, zero fill
);

  pt_t  in_pt;
  op_t  in_op;
  logic push;
  job_t push_job;
  logic queue_full;
  logic head_valid;
  job_t head_job;
  logic job_pop;
  logic out_inside;

  assign in_pt.x = coord_t'(s_tdata[COORD_WIDTH-1:0]);
  assign in_pt.y = coord_t'(s_tdata[DATA_WIDTH-1:COORD_WIDTH]);
  assign in_op   = op_t'(s_tuser);

  pipc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_op      (in_op),
    .in_pt      (in_pt),
    .in_last    (s_tlast),
    .queue_full (queue_full),
    .in_ready   (s_tready),
    .push       (push),
    .push_job   (push_job)
  );

  pipc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (job_pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  pipc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (head_valid),
    .job        (head_job),
    .job_pop    (job_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_inside (out_inside)
  );

  assign m_tdata = {{(OUT_WIDTH-1){1'b0}}, out_inside};

endmodule
